// ----- sv/ptb_pkg.sv -----
// shared types and constants for the periodic timer bank
`default_nettype none

package ptb_pkg;

   localparam int TIMER_CNT_DEFAULT = 16;
   localparam logic [31:0] NONE_READY = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      OP_SERVICE = 4'd0,
      OP_ADVANCE = 4'd1,
      OP_CREATE  = 4'd2,
      OP_DESTROY = 4'd3,
      OP_PAUSE   = 4'd4,
      OP_RESUME  = 4'd5,
      OP_READY   = 4'd6,
      OP_RESTART = 4'd7,
      OP_REPEAT  = 4'd8,
      OP_AUTODEL = 4'd9,
      OP_PERIOD  = 4'd10
   } op_type;

   // command broadcast to every slot cell
   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [3:0]         slot;
      logic [31:0]        amount;
      logic signed [31:0] repeat_value;
      logic               auto_delete_flag;
   } cmd_type;

   // service token and running minimum handed from cell to cell
   typedef struct packed {
      logic        tok;
      logic [31:0] tmin;
   } link_type;

endpackage

`default_nettype wire

// ----- sv/periodic_timer_bank_unit.sv -----
// top level of the periodic timer bank: slot cell chain, tick count and result register
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: op, tdata: slot, amount, repeat, auto-delete
//  rsp     | out | rsp_tvalid/rsp_tready | tuser: kind, tdata: slot, time, tlast: summary
//
// every command but service leaves the request channel ready, so the next request follows right after
// a service passes a token down the slot cells, one cell per cycle while the chain is not
// frozen; the summary goes through the summary stage into the result register, and the next
// request is taken once the summary is loaded there
// the chain freezes while the result register is full and not being taken
// reset clears the tick count and all active and pause marks at once
`default_nettype none

module periodic_timer_bank_unit #(
   parameter int NUM_TIMERS = ptb_pkg::TIMER_CNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [3:0]  req_tuser,   // [3:0] req_type
   input  logic [71:0] req_tdata,   // [3:0] slot, [35:4] amount, [67:36] repeat_value,
                                    // [68] auto_delete_flag, [71:69] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // [0] result_kind
   output logic [39:0] rsp_tdata,   // [3:0] fired_slot, [35:4] next_due, [39:36] zero
   output logic        rsp_tlast    // last
);
   import ptb_pkg::*;

   logic [31:0] tick_ff, tick_in;
   logic        busy_ff, busy_in;
   logic        sum_pend_ff, sum_pend_in;
   logic [31:0] sum_min_ff, sum_min_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [31:0] rsp_time_ff, rsp_time_in;
   logic        rsp_last_ff, rsp_last_in;

   cmd_type                 cmd;
   logic                    req_accept;
   logic                    svc_start;
   logic                    step_en;
   logic                    sum_load;
   logic [NUM_TIMERS-1:0]   fire_vec;
   logic [3:0]              fire_slot;
   link_type                links [NUM_TIMERS+1];

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign step_en    = !rsp_valid_ff || rsp_tready;
   assign sum_load   = sum_pend_ff && step_en;

   assign cmd.valid            = req_accept;
   assign cmd.op               = op_type'(req_tuser);
   assign cmd.slot             = req_tdata[3:0];
   assign cmd.amount           = req_tdata[35:4];
   assign cmd.repeat_value     = $signed(req_tdata[67:36]);
   assign cmd.auto_delete_flag = req_tdata[68];

   assign svc_start     = req_accept && (cmd.op == OP_SERVICE);
   assign links[0].tok  = svc_start;
   assign links[0].tmin = NONE_READY;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      ptb_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .tick_now (tick_ff),
         .step_en  (step_en),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .fire     (fire_vec[i])
      );
   end

   // only the cell holding the token can fire
   always_comb begin
      fire_slot = 4'd0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (fire_vec[i]) begin
            fire_slot = 4'(i);
         end
      end
   end

   always_comb begin
      tick_in      = tick_ff;
      busy_in      = busy_ff;
      sum_pend_in  = sum_pend_ff;
      sum_min_in   = sum_min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_accept && (cmd.op == OP_ADVANCE)) begin
         tick_in = tick_ff + cmd.amount;
      end
      if (svc_start) begin
         busy_in = 1'b1;
      end

      // last cell hands off into the summary stage
      if (links[NUM_TIMERS].tok) begin
         sum_pend_in = 1'b1;
         sum_min_in  = links[NUM_TIMERS].tmin;
      end else if (sum_load) begin
         sum_pend_in = 1'b0;
         busy_in     = 1'b0;
      end

      if (|fire_vec) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = 1'b0;
         rsp_slot_in  = fire_slot;
         rsp_time_in  = 32'd0;
         rsp_last_in  = 1'b0;
      end else if (sum_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = 1'b1;
         rsp_slot_in  = 4'd0;
         rsp_time_in  = sum_min_ff;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= 32'd0;
         busy_ff      <= 1'b0;
         sum_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         busy_ff      <= busy_in;
         sum_pend_ff  <= sum_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_min_ff  <= sum_min_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {4'd0, rsp_time_ff, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_single_fire: assert property (@(posedge clock) disable iff (reset)
      $onehot0({fire_vec, sum_load}))
      else $error("more than one result produced in a cycle");

   a_summary_busy: assert property (@(posedge clock) disable iff (reset)
      sum_pend_ff |-> busy_ff)
      else $error("summary pending outside a service walk");

   a_service_locks: assert property (@(posedge clock) disable iff (reset)
      svc_start |=> (busy_ff && !req_tready))
      else $error("service walk did not block new requests");

endmodule

`default_nettype wire

// ----- sv/ptb_cell.sv -----
// one timer slot: its state, command decode and service step
`default_nettype none

module ptb_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  ptb_pkg::cmd_type  cmd,
   input  logic [31:0]       tick_now,
   input  logic              step_en,
   input  ptb_pkg::link_type link_in,
   output ptb_pkg::link_type link_out,
   output logic              fire
);
   import ptb_pkg::*;

   logic               active_ff, active_in;
   logic               paused_ff, paused_in;
   logic               auto_del_ff, auto_del_in;
   logic [31:0]        period_ff, period_in;
   logic [31:0]        last_run_ff, last_run_in;
   logic signed [31:0] repeats_ff, repeats_in;
   logic               tok_ff, tok_in;
   logic [31:0]        tmin_ff, tmin_in;

   logic        hit;
   logic [31:0] elapsed;
   logic        due;
   logic [31:0] rem;
   logic        live;
   logic        serve;
   logic        dec;
   logic        freed;
   logic        keep;

   assign hit     = cmd.valid && ({28'd0, cmd.slot} == 32'(CELL_INDEX));
   assign elapsed = tick_now - last_run_ff;
   assign due     = elapsed >= period_ff;
   // a slot that fires restarts at zero elapsed, so its remaining time is the period
   assign rem     = due ? period_ff : (period_ff - elapsed);
   assign live    = active_ff && !paused_ff;
   assign serve   = tok_ff && step_en;
   assign fire    = serve && live && due;
   assign dec     = fire && (repeats_ff > 32'sd0);
   assign freed   = dec && (repeats_ff == 32'sd1) && auto_del_ff;
   assign keep    = live && !freed;

   assign link_out.tok  = serve;
   assign link_out.tmin = (keep && (rem < tmin_ff)) ? rem : tmin_ff;

   always_comb begin
      active_in   = active_ff;
      paused_in   = paused_ff;
      auto_del_in = auto_del_ff;
      period_in   = period_ff;
      last_run_in = last_run_ff;
      repeats_in  = repeats_ff;
      tmin_in     = tmin_ff;
      if (link_in.tok) begin
         tok_in  = 1'b1;
         tmin_in = link_in.tmin;
      end else if (serve) begin
         tok_in = 1'b0;
      end else begin
         tok_in = tok_ff;
      end

      if (fire) begin
         last_run_in = tick_now;
         if (dec) begin
            repeats_in = repeats_ff - 32'sd1;
         end
         if (freed) begin
            active_in = 1'b0;
         end
      end

      if (hit) begin
         if (cmd.op == OP_CREATE) begin
            period_in   = cmd.amount;
            last_run_in = tick_now;
            repeats_in  = cmd.repeat_value;
            paused_in   = 1'b0;
            auto_del_in = 1'b1;
            active_in   = 1'b1;
         end else if (active_ff) begin
            case (cmd.op)
               OP_DESTROY: active_in   = 1'b0;
               OP_PAUSE:   paused_in   = 1'b1;
               OP_RESUME:  paused_in   = 1'b0;
               OP_READY:   last_run_in = tick_now - period_ff;
               OP_RESTART: last_run_in = tick_now;
               OP_REPEAT:  repeats_in  = cmd.repeat_value;
               OP_AUTODEL: auto_del_in = cmd.auto_delete_flag;
               OP_PERIOD:  period_in   = cmd.amount;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         paused_ff <= 1'b0;
         tok_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         paused_ff <= paused_in;
         tok_ff    <= tok_in;
      end
      auto_del_ff <= auto_del_in;
      period_ff   <= period_in;
      last_run_ff <= last_run_in;
      repeats_ff  <= repeats_in;
      tmin_ff     <= tmin_in;
   end

endmodule

`default_nettype wire

// ----- verif/tb_periodic_timer_bank_unit.sv -----
// self-checking testbench for the periodic timer bank: directed, random, timer-round and backpressure tests
`timescale 1ns / 100ps

module tb_periodic_timer_bank_unit;
   import ptb_pkg::*;

   localparam int TIMERS       = TIMER_CNT_DEFAULT;
   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 8;
   localparam int MAX_WAIT     = 18;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 2 * TIMERS + 8;
   localparam int SHOWN_ERRORS = 10;
   localparam logic [3:0] OP_CODE_MAX = 4'hF;

   typedef struct packed {
      logic        kind;
      logic [3:0]  fired;
      logic [31:0] until_next;
      logic        last;
   } timer_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [3:0]  req_tuser = '0;   // [3:0] req_type
   logic [71:0] req_tdata = '0;   // [3:0] slot, [35:4] amount, [67:36] repeat_value,
                                  // [68] auto_delete_flag, [71:69] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [0:0]  rsp_tuser;        // [0] result_kind
   logic [39:0] rsp_tdata;        // [3:0] fired_slot, [35:4] next_due, [39:36] zero
   logic        rsp_tlast;

   // predicted bank state
   logic [31:0]        tick_now = '0;
   bit                 slot_active [TIMERS];
   bit                 slot_paused [TIMERS];
   bit                 slot_auto_delete [TIMERS];
   logic [31:0]        slot_period [TIMERS];
   logic [31:0]        slot_last_run [TIMERS];
   logic signed [31:0] slot_repeats_left [TIMERS];

   timer_report_type pending_reports [$];
   int               fail_count = 0;
   int               effective_count = 0;
   int               quiet_cycles = 0;
   int unsigned      req_gap_max = MAX_WAIT;
   int unsigned      rsp_stall_max = MAX_WAIT;
   int unsigned      rsp_hold_cycles = 0;

   periodic_timer_bank_unit #(.NUM_TIMERS(TIMERS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= SHOWN_ERRORS) $display("error: %s", msg);
   endfunction

   function automatic void push_report(input logic kind, input logic [3:0] fired,
                                       input logic [31:0] until_next, input logic last);
      timer_report_type rpt;
      rpt.kind       = kind;
      rpt.fired      = fired;
      rpt.until_next = until_next;
      rpt.last       = last;
      pending_reports.push_back(rpt);
   endfunction

   // updates the predicted bank and queues the reports; returns 0 when the request is ignored
   function automatic bit apply_timer_command(input logic [3:0] op, input logic [3:0] slot,
                                              input logic [31:0] amount, input logic [31:0] rep,
                                              input logic adel);
      logic [31:0] best;
      logic [31:0] elapsed;
      logic [31:0] rem;
      if (op == OP_SERVICE) begin
         for (int s = 0; s < TIMERS; s++) begin
            if (slot_active[s] && !slot_paused[s] &&
                (tick_now - slot_last_run[s]) >= slot_period[s]) begin
               slot_last_run[s] = tick_now;
               push_report(1'b0, 4'(s), '0, 1'b0);
               if (slot_repeats_left[s] > 0) begin
                  slot_repeats_left[s] = slot_repeats_left[s] - 1;
                  if (slot_repeats_left[s] == 0 && slot_auto_delete[s]) slot_active[s] = 1'b0;
               end
            end
         end
         best = NONE_READY;
         for (int s = 0; s < TIMERS; s++) begin
            if (slot_active[s] && !slot_paused[s]) begin
               elapsed = tick_now - slot_last_run[s];
               rem = (elapsed >= slot_period[s]) ? '0 : slot_period[s] - elapsed;
               if (rem < best) best = rem;
            end
         end
         push_report(1'b1, '0, best, 1'b1);
         return 1'b1;
      end
      if (op == OP_ADVANCE) begin
         tick_now = tick_now + amount;
         return 1'b1;
      end
      if (op > OP_PERIOD || slot >= TIMERS) return 1'b0;
      if (op == OP_CREATE) begin
         slot_period[slot]       = amount;
         slot_last_run[slot]     = tick_now;
         slot_repeats_left[slot] = rep;
         slot_paused[slot]       = 1'b0;
         slot_auto_delete[slot]  = 1'b1;
         slot_active[slot]       = 1'b1;
         return 1'b1;
      end
      if (!slot_active[slot]) return 1'b0;
      case (op)
         OP_DESTROY: slot_active[slot] = 1'b0;
         OP_PAUSE:   slot_paused[slot] = 1'b1;
         OP_RESUME:  slot_paused[slot] = 1'b0;
         OP_READY:   slot_last_run[slot] = tick_now - slot_period[slot];
         OP_RESTART: slot_last_run[slot] = tick_now;
         OP_REPEAT:  slot_repeats_left[slot] = rep;
         OP_AUTODEL: slot_auto_delete[slot] = adel;
         default:    slot_period[slot] = amount;
      endcase
      return 1'b1;
   endfunction

   function automatic int unsigned draw_wait(input int unsigned max_wait);
      if (max_wait == 0 || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, max_wait);
   endfunction

   // mostly short periods and steps, now and then zero or a full-range value
   function automatic logic [31:0] rand_ticks();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return '0;
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   function automatic logic [31:0] rand_repeat();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return int'($urandom_range(0, 6)) - 2;
   endfunction

   function automatic void shuffle_idling();
      req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
      rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
   endfunction

   task automatic send_request(input logic [3:0] op, input logic [3:0] slot,
                               input logic [31:0] amount, input logic [31:0] rep,
                               input logic adel);
      int unsigned gap;
      gap = draw_wait(req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, adel, rep, amount, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (apply_timer_command(op, slot, amount, rep, adel)) effective_count++;
   endtask

   task automatic wait_reports_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic test_directed_cases();
      send_request(OP_SERVICE, 4'd0, '0, '0, 1'b0);          // empty bank reports none ready
      send_request(OP_CREATE, 4'd0, 32'd5, 32'd2, 1'b0);
      send_request(OP_CREATE, 4'd15, 32'd0, 32'd0, 1'b1);     // zero period is always due
      send_request(OP_CREATE, 4'd3, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
      send_request(OP_CREATE, 4'd7, 32'd1, 32'h7FFF_FFFF, 1'b1);
      send_request(OP_SERVICE, 4'd0, '0, '0, 1'b0);
      send_request(OP_ADVANCE, 4'd0, 32'd5, '0, 1'b0);
      send_request(OP_SERVICE, 4'd0, '0, '0, 1'b0);
      send_request(OP_ADVANCE, 4'd0, 32'd5, '0, 1'b0);
      send_request(OP_SERVICE, 4'd0, '0, '0, 1'b0);          // slot 0 runs out and is freed
      send_request(OP_PAUSE, 4'd15, '0, '0, 1'b0);
      send_request(OP_PAUSE, 4'd3, '0, '0, 1'b0);
      send_request(OP_RESUME, 4'd3, '0, '0, 1'b0);
      send_request(OP_READY, 4'd3, '0, '0, 1'b0);
      send_request(OP_AUTODEL, 4'd3, '0, '0, 1'b0);
      send_request(OP_REPEAT, 4'd3, '0, 32'd1, 1'b0);
      send_request(OP_SERVICE, 4'd0, '0, '0, 1'b0);          // slot 3 runs out but stays
      send_request(OP_PERIOD, 4'd3, 32'd2, '0, 1'b0);
      send_request(OP_RESTART, 4'd7, '0, '0, 1'b0);
      send_request(OP_ADVANCE, 4'd0, 32'hFFFF_FFFF, '0, 1'b0); // tick count wraps
      send_request(OP_SERVICE, 4'd0, '0, '0, 1'b0);
      send_request(OP_DESTROY, 4'd3, '0, '0, 1'b0);
      send_request(OP_DESTROY, 4'd3, '0, '0, 1'b0);          // inactive slot, ignored
      send_request(OP_PERIOD + 4'd1, 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(OP_CODE_MAX, 4'd7, '0, '0, 1'b0);
      send_request(OP_SERVICE, 4'd0, '0, '0, 1'b0);
   endtask

   task automatic test_random_mix();
      int unsigned pick;
      int          target;
      logic [3:0]  op;
      target = effective_count + 200;
      while (effective_count < target) begin
         if ($urandom_range(0, 39) == 0) shuffle_idling();
         pick = $urandom_range(0, 19);
         if (pick < 4) op = OP_SERVICE;
         else if (pick < 7) op = OP_ADVANCE;
         else if (pick < 10) op = OP_CREATE;
         else op = 4'($urandom_range(OP_DESTROY, OP_CODE_MAX));
         send_request(op, 4'($urandom_range(0, TIMERS - 1)), rand_ticks(), rand_repeat(),
                      1'($urandom));
      end
   endtask

   // well-formed rounds: set up or retune a slot, step time, then service
   task automatic test_timer_rounds();
      int         target;
      logic [3:0] slot;
      target = effective_count + 180;
      while (effective_count < target) begin
         if ($urandom_range(0, 29) == 0) shuffle_idling();
         slot = 4'($urandom_range(0, TIMERS - 1));
         if ($urandom_range(0, 2) == 0)
            send_request(OP_CREATE, slot, $urandom_range(1, 12),
                         int'($urandom_range(0, 5)) - 1, 1'($urandom));
         else if ($urandom_range(0, 1) == 0)
            send_request(4'($urandom_range(OP_DESTROY, OP_PERIOD)), slot,
                         $urandom_range(0, 12), int'($urandom_range(0, 5)) - 1, 1'($urandom));
         send_request(OP_ADVANCE, 4'($urandom), $urandom_range(0, 8), $urandom, 1'($urandom));
         send_request(OP_SERVICE, 4'($urandom), $urandom, $urandom, 1'($urandom));
      end
   endtask

   // receiver stops for a long stretch while every slot fires on each service
   task automatic test_backpressure();
      req_gap_max     = 0;
      rsp_stall_max   = MAX_WAIT;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int s = 0; s < TIMERS; s++) send_request(OP_CREATE, 4'(s), '0, '0, 1'b0);
      repeat (20) send_request(OP_SERVICE, '0, '0, '0, 1'b0);
   endtask

   // result side: random stalls, plus one long hold-off when asked
   initial begin : rsp_side
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = draw_wait(rsp_stall_max);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_reports
      timer_report_type seen;
      timer_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind       = rsp_tuser[0];
         seen.fired      = rsp_tdata[3:0];
         seen.until_next = rsp_tdata[35:4];
         seen.last       = rsp_tlast;
         if (pending_reports.size() == 0) begin
            note_failure($sformatf("unexpected report kind %0d slot %0d next %h last %0d",
                                   seen.kind, seen.fired, seen.until_next, seen.last));
         end else begin
            want = pending_reports.pop_front();
            if (seen !== want)
               note_failure($sformatf({"expected kind %0d slot %0d next %h last %0d, ",
                                       "got kind %0d slot %0d next %h last %0d"},
                                      want.kind, want.fired, want.until_next, want.last,
                                      seen.kind, seen.fired, seen.until_next, seen.last));
         end
      end
   end

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no request or report moved for %0d cycles", QUIET_LIMIT);
         $display("tb_periodic_timer_bank_unit: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_reports_drained();
      test_random_mix();
      wait_reports_drained();
      test_timer_rounds();
      wait_reports_drained();
      test_backpressure();
      wait_reports_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0)
         note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
      if (fail_count == 0)
         $display("tb_periodic_timer_bank_unit: PASS");
      else
         $display("tb_periodic_timer_bank_unit: FAIL");
      $finish;
   end

endmodule
